### rtl/bst_pkg.sv
// Package for the bencode stream tokenizer: parse phases, codes and character constants.
package bst_pkg;

   // parse phase of the tokenizer
   typedef enum logic [2:0] {
      PH_ITEM     = 3'd0,
      PH_INT_SIGN = 3'd1,
      PH_INT_DIG  = 3'd2,
      PH_LEN      = 3'd3,
      PH_BODY     = 3'd4,
      PH_DONE     = 3'd5,
      PH_ERR      = 3'd6
   } phase_type;

   // state of one open container
   typedef enum logic [1:0] {
      LV_LIST     = 2'd0,
      LV_DICT_KEY = 2'd1,
      LV_DICT_VAL = 2'd2
   } level_type;

   // token event reported with each request
   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_INT   = 3'd1,
      EV_HDR   = 3'd2,
      EV_BYTE  = 3'd3,
      EV_LIST  = 3'd4,
      EV_DICT  = 3'd5,
      EV_CLOSE = 3'd6
   } event_type;

   // sticky error codes
   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_UNEXP   = 3'd1,
      ERR_TRUNC   = 3'd2,
      ERR_DEEP    = 3'd3,
      ERR_LEN_OVF = 3'd4
   } err_type;

   // characters of the encoding
   localparam logic [7:0] CH_INT   = 8'h69;  // 'i'
   localparam logic [7:0] CH_LIST  = 8'h6C;  // 'l'
   localparam logic [7:0] CH_DICT  = 8'h64;  // 'd'
   localparam logic [7:0] CH_END   = 8'h65;  // 'e'
   localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
   localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

   // result packing
   localparam int DATA_BITS = 152;

   // a value completed inside a container: move a dict to its other slot
   function automatic level_type flip_level(input level_type lv);
      level_type r;
      r = lv;
      if (lv == LV_DICT_KEY) begin
         r = LV_DICT_VAL;
      end else if (lv == LV_DICT_VAL) begin
         r = LV_DICT_KEY;
      end
      return r;
   endfunction

endpackage

### rtl/bencode_stream_tokenizer.sv
// Bencode stream tokenizer: one byte per request in, one token event per request out.
// Result: a request accepted at one clock edge shows its result on rsp_* right after that edge.
// Throughput: one request per cycle while results are taken; the shift-add of the integer and length digits and the
//   nesting stack (one write and one registered read per cycle) all keep that pace.
// Backpressure: req_tready follows the single result register (empty or being taken).
// Reset: synchronous, active high; clears the parse state, counters and the result valid flag.
//   The nesting stack holds no reset value; an entry is always written before it is read.
module bencode_stream_tokenizer
   import bst_pkg::*;
#(
   parameter int MAX_DEPTH  = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_byte
   input  logic                 req_tuser,   // [0] first_of_buffer
   input  logic                 req_tlast,   // last_of_buffer
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata,   // [63:0] int_value, [95:64] string_length,
                                             // [103:96] payload_byte, [104] is_dict_key,
                                             // [109:105] nesting_level, [110] top_done,
                                             // [113:111] error_code, [145:114] bytes_consumed,
                                             // [151:146] zero
   output logic [2:0]           rsp_tuser    // [2:0] event_kind
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int LEN_W   = COUNT_BITS + 4;

   // parse state
   phase_type              phase_ff, phase_in;
   logic [63:0]            iacc_ff, iacc_in;
   logic                   neg_ff, neg_in;
   logic [COUNT_BITS-1:0]  lacc_ff, lacc_in;
   logic [COUNT_BITS-1:0]  body_ff, body_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;
   level_type              top_ff, top_in;
   logic                   key_ff, key_in;
   logic [COUNT_BITS-1:0]  pos_ff, pos_in;
   err_type                err_ff, err_in;

   // nesting stack below the top level: post-close state of each parent
   level_type              stack_mem [MAX_DEPTH];
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_idx;
   level_type              wr_data;
   logic [DEPTH_W-1:0]     rd_dep;
   logic [IDX_W-1:0]       rd_idx;
   level_type              below_rd_ff;
   logic                   fwd_ff;
   level_type              fwd_data_ff;
   level_type              below;

   // result register
   logic                   rsp_valid_ff;
   event_type              ev_kind;
   event_type              rsp_kind_ff;
   logic [63:0]            rsp_ival_ff, rsp_ival_in;
   logic [31:0]            rsp_slen_ff, rsp_slen_in;
   logic [7:0]             rsp_pbyte_ff, rsp_pbyte_in;
   logic                   rsp_key_ff, rsp_key_in;
   logic [4:0]             rsp_nest_ff, rsp_nest_in;
   logic                   rsp_done_ff, rsp_done_in;
   err_type                rsp_err_ff;
   logic [31:0]            rsp_pos_ff, rsp_pos_in;

   // state as seen by this request (first_of_buffer restarts it)
   logic                   req_accept;
   logic                   restart;
   phase_type              cur_phase;
   logic [63:0]            cur_iacc;
   logic                   cur_neg;
   logic [COUNT_BITS-1:0]  cur_lacc;
   logic [COUNT_BITS-1:0]  cur_body;
   logic [DEPTH_W-1:0]     cur_depth;
   logic                   cur_key;
   logic [COUNT_BITS-1:0]  cur_pos;
   err_type                cur_err;
   logic                   at_top;
   level_type              tk;

   // digit arithmetic
   logic                   is_digit;
   logic [3:0]             digit;
   logic [63:0]            iacc_step;
   logic [LEN_W-1:0]       lacc_wide;
   logic [LEN_W-1:0]       lacc_step;
   logic                   len_ovf;
   logic [COUNT_BITS-1:0]  body_dec;

   // handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign restart    = req_accept && req_tuser;

   assign cur_phase = restart ? PH_ITEM : phase_ff;
   assign cur_iacc  = restart ? 64'd0 : iacc_ff;
   assign cur_neg   = restart ? 1'b0 : neg_ff;
   assign cur_lacc  = restart ? '0 : lacc_ff;
   assign cur_body  = restart ? '0 : body_ff;
   assign cur_depth = restart ? '0 : depth_ff;
   assign cur_key   = restart ? 1'b0 : key_ff;
   assign cur_pos   = restart ? '0 : pos_ff;
   assign cur_err   = restart ? ERR_NONE : err_ff;
   assign at_top    = (cur_depth == '0);
   assign tk        = at_top ? LV_LIST : top_ff;

   // digit decode and shift-add by ten
   assign is_digit  = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
   assign digit     = req_tdata[3:0];
   assign iacc_step = (cur_iacc << 3) + (cur_iacc << 1) + 64'(digit);
   assign lacc_wide = LEN_W'(cur_lacc);
   assign lacc_step = (lacc_wide << 3) + (lacc_wide << 1) + LEN_W'(digit);
   assign len_ovf   = |lacc_step[LEN_W-1:COUNT_BITS];
   assign body_dec  = cur_body - COUNT_BITS'(1);

   // parent entry below the top: registered read with write forwarding
   assign below  = fwd_ff ? fwd_data_ff : below_rd_ff;
   assign rd_dep = depth_in - DEPTH_W'(2);
   assign rd_idx = rd_dep[IDX_W-1:0];

   // next state
   always_comb begin
      err_type   step_err;
      logic      vdone;
      logic [DEPTH_W-1:0] dep_m1;
      phase_in = phase_ff;
      iacc_in  = iacc_ff;
      neg_in   = neg_ff;
      lacc_in  = lacc_ff;
      body_in  = body_ff;
      depth_in = depth_ff;
      top_in   = top_ff;
      key_in   = key_ff;
      pos_in   = pos_ff;
      err_in   = err_ff;
      ev_kind  = EV_NONE;
      wr_en    = 1'b0;
      dep_m1   = cur_depth - DEPTH_W'(1);
      wr_idx   = dep_m1[IDX_W-1:0];
      wr_data  = flip_level(tk);
      step_err = ERR_NONE;
      vdone    = 1'b0;
      if (req_accept) begin
         phase_in = cur_phase;
         iacc_in  = cur_iacc;
         neg_in   = cur_neg;
         lacc_in  = cur_lacc;
         body_in  = cur_body;
         depth_in = cur_depth;
         key_in   = cur_key;
         pos_in   = cur_pos;
         err_in   = cur_err;
         unique case (cur_phase)
            PH_ITEM: begin
               if (req_tdata == CH_END) begin
                  if (at_top || tk == LV_DICT_VAL) begin
                     step_err = ERR_UNEXP;
                  end else begin
                     // pop: the parent entry already holds its post-close slot
                     depth_in = dep_m1;
                     ev_kind  = EV_CLOSE;
                     if (dep_m1 == '0) begin
                        phase_in = PH_DONE;
                     end else begin
                        top_in   = below;
                        phase_in = PH_ITEM;
                     end
                  end
               end else if (is_digit) begin
                  key_in   = !at_top && tk == LV_DICT_KEY;
                  lacc_in  = COUNT_BITS'(digit);
                  phase_in = PH_LEN;
               end else if (!at_top && tk == LV_DICT_KEY) begin
                  step_err = ERR_UNEXP;
               end else if (req_tdata == CH_INT) begin
                  iacc_in  = 64'd0;
                  neg_in   = 1'b0;
                  phase_in = PH_INT_SIGN;
               end else if (req_tdata == CH_LIST || req_tdata == CH_DICT) begin
                  if (cur_depth >= DEPTH_W'(MAX_DEPTH)) begin
                     step_err = ERR_DEEP;
                  end else begin
                     // push: park the parent in the stack, the new container is the top
                     wr_en    = !at_top;
                     top_in   = (req_tdata == CH_LIST) ? LV_LIST : LV_DICT_KEY;
                     depth_in = cur_depth + DEPTH_W'(1);
                     ev_kind  = (req_tdata == CH_LIST) ? EV_LIST : EV_DICT;
                     phase_in = PH_ITEM;
                  end
               end else begin
                  step_err = ERR_UNEXP;
               end
            end
            PH_INT_SIGN, PH_INT_DIG: begin
               if (cur_phase == PH_INT_SIGN && req_tdata == CH_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = PH_INT_DIG;
               end else if (is_digit) begin
                  iacc_in  = iacc_step;
                  phase_in = PH_INT_DIG;
               end else if (req_tdata == CH_END) begin
                  ev_kind = EV_INT;
                  vdone   = 1'b1;
               end else begin
                  step_err = ERR_UNEXP;
               end
            end
            PH_LEN: begin
               if (is_digit) begin
                  if (len_ovf) begin
                     step_err = ERR_LEN_OVF;
                  end else begin
                     lacc_in = lacc_step[COUNT_BITS-1:0];
                  end
               end else if (req_tdata == CH_COLON) begin
                  ev_kind = EV_HDR;
                  body_in = cur_lacc;
                  if (cur_lacc == '0) begin
                     vdone = 1'b1;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end else begin
                  step_err = ERR_UNEXP;
               end
            end
            PH_BODY: begin
               ev_kind = EV_BYTE;
               body_in = body_dec;
               vdone   = (body_dec == '0);
            end
            PH_DONE, PH_ERR: begin
               // parse finished: bytes are ignored until a restart
            end
            default: begin
               step_err = ERR_UNEXP;
            end
         endcase

         // a value completed: finish the parse or advance the enclosing slot
         if (vdone) begin
            if (at_top) begin
               phase_in = PH_DONE;
            end else begin
               top_in   = flip_level(top_ff);
               phase_in = PH_ITEM;
            end
         end

         // sticky error, byte count and truncation
         if (cur_phase != PH_DONE && cur_phase != PH_ERR) begin
            if (step_err != ERR_NONE) begin
               err_in   = step_err;
               phase_in = PH_ERR;
            end else begin
               pos_in = cur_pos + COUNT_BITS'(1);
               if (req_tlast && phase_in != PH_DONE) begin
                  err_in   = ERR_TRUNC;
                  phase_in = PH_ERR;
               end
            end
         end
      end
   end

   // result fields
   always_comb begin
      rsp_ival_in  = 64'd0;
      rsp_slen_in  = 32'd0;
      rsp_pbyte_in = 8'd0;
      rsp_key_in   = 1'b0;
      case (ev_kind)
         EV_INT: begin
            rsp_ival_in = cur_neg ? (64'd0 - cur_iacc) : cur_iacc;
         end
         EV_HDR: begin
            rsp_slen_in = 32'(cur_lacc);
            rsp_key_in  = cur_key;
         end
         EV_BYTE: begin
            rsp_pbyte_in = req_tdata;
            rsp_key_in   = cur_key;
         end
         default: begin
         end
      endcase
      rsp_nest_in = 5'(depth_in);
      rsp_done_in = (phase_in == PH_DONE);
      rsp_pos_in  = 32'(pos_in);
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ITEM;
         iacc_ff  <= 64'd0;
         neg_ff   <= 1'b0;
         lacc_ff  <= '0;
         body_ff  <= '0;
         depth_ff <= '0;
         top_ff   <= LV_LIST;
         key_ff   <= 1'b0;
         pos_ff   <= '0;
         err_ff   <= ERR_NONE;
         fwd_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         iacc_ff  <= iacc_in;
         neg_ff   <= neg_in;
         lacc_ff  <= lacc_in;
         body_ff  <= body_in;
         depth_ff <= depth_in;
         top_ff   <= top_in;
         key_ff   <= key_in;
         pos_ff   <= pos_in;
         err_ff   <= err_in;
         fwd_ff   <= wr_en && (wr_idx == rd_idx);
      end
   end

   // nesting stack memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_idx] <= wr_data;
      end
      below_rd_ff <= stack_mem[rd_idx];
      fwd_data_ff <= wr_data;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_kind_ff  <= ev_kind;
         rsp_ival_ff  <= rsp_ival_in;
         rsp_slen_ff  <= rsp_slen_in;
         rsp_pbyte_ff <= rsp_pbyte_in;
         rsp_key_ff   <= rsp_key_in;
         rsp_nest_ff  <= rsp_nest_in;
         rsp_done_ff  <= rsp_done_in;
         rsp_err_ff   <= err_in;
         rsp_pos_ff   <= rsp_pos_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'd0, rsp_pos_ff, rsp_err_ff, rsp_done_ff, rsp_nest_ff, rsp_key_ff,
                        rsp_pbyte_ff, rsp_slen_ff, rsp_ival_ff};

   // checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(MAX_DEPTH))
      else $error("nesting depth above MAX_DEPTH");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> body_ff != '0)
      else $error("string body phase with nothing remaining");

   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERR) == (err_ff != ERR_NONE))
      else $error("sticky error and error phase disagree");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(pos_ff))
      else $error("byte count moved without a request");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_err_ff == ERR_NONE)
      else $error("completion reported together with an error");

endmodule

### dv/bencode_stream_tokenizer_tb.sv
// Self-checking testbench for the bencode stream tokenizer: directed and random buffers.
module bencode_stream_tokenizer_tb
   import bst_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH_LIMIT = 16;
   localparam int LEN_BITS    = 32;

   // expected token event for one request
   typedef struct packed {
      event_type   kind;
      logic [63:0] ival;
      logic [31:0] slen;
      logic [7:0]  pbyte;
      logic        key;
      logic [4:0]  nest;
      logic        done;
      err_type     err;
      logic [31:0] consumed;
   } token_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = 8'd0;
   logic                 req_tuser  = 1'b0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic [2:0]           rsp_tuser;

   // parser state mirrored by the predictor
   phase_type   parse_st;
   logic [63:0] int_acc;
   logic        int_neg;
   logic [63:0] len_acc;
   logic [63:0] body_left;
   int          depth;
   level_type   lvl_stack[DEPTH_LIMIT];
   logic [31:0] pos;
   err_type     sticky;
   logic        in_key;

   token_type   token_q[$];
   logic [7:0]  enc_q[$];

   int          mismatch_count = 0;
   int          sent_count     = 0;
   int          buffer_count   = 0;
   int          done_count     = 0;
   int          stall_cycles   = 0;
   int          ev_hits[8];
   int          err_hits[8];
   bit          steady_flow    = 1'b0;
   int          rsp_hold_cycles = 0;

   bencode_stream_tokenizer #(
      .MAX_DEPTH (DEPTH_LIMIT),
      .COUNT_BITS(LEN_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   // run limit
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   // gap length: mostly none or short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit is_decimal(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic void restart_parse();
      parse_st  = PH_ITEM;
      int_acc   = '0;
      int_neg   = 1'b0;
      len_acc   = '0;
      body_left = '0;
      depth     = 0;
      pos       = '0;
      sticky    = ERR_NONE;
      in_key    = 1'b0;
   endfunction

   // a value finished: top level completes, a dict toggles between key and value slot
   function automatic void finish_value();
      if (depth == 0) begin
         parse_st = PH_DONE;
         done_count++;
      end else begin
         if (lvl_stack[depth-1] == LV_DICT_KEY) begin
            lvl_stack[depth-1] = LV_DICT_VAL;
         end else if (lvl_stack[depth-1] == LV_DICT_VAL) begin
            lvl_stack[depth-1] = LV_DICT_KEY;
         end
         parse_st = PH_ITEM;
      end
   endfunction

   // predict the token event of one accepted request and queue it
   function automatic void tokenize_byte(input logic [7:0] b, input bit first, input bit last);
      token_type   t;
      err_type     e;
      level_type   lv;
      logic [63:0] dig;
      t   = '0;
      e   = ERR_NONE;
      dig = {56'd0, b - CH_ZERO};
      if (first) restart_parse();
      if (parse_st != PH_DONE && parse_st != PH_ERR) begin
         lv = (depth == 0) ? LV_LIST : lvl_stack[depth-1];
         case (parse_st)
            PH_ITEM: begin
               if (b == CH_END) begin
                  if (depth == 0 || lv == LV_DICT_VAL) begin
                     e = ERR_UNEXP;
                  end else begin
                     depth--;
                     t.kind = EV_CLOSE;
                     finish_value();
                  end
               end else if (is_decimal(b)) begin
                  in_key   = (depth != 0 && lv == LV_DICT_KEY);
                  len_acc  = dig;
                  parse_st = PH_LEN;
               end else if (depth != 0 && lv == LV_DICT_KEY) begin
                  e = ERR_UNEXP;
               end else if (b == CH_INT) begin
                  int_acc  = '0;
                  int_neg  = 1'b0;
                  parse_st = PH_INT_SIGN;
               end else if (b == CH_LIST || b == CH_DICT) begin
                  if (depth >= DEPTH_LIMIT) begin
                     e = ERR_DEEP;
                  end else if (b == CH_LIST) begin
                     lvl_stack[depth] = LV_LIST;
                     depth++;
                     t.kind = EV_LIST;
                  end else begin
                     lvl_stack[depth] = LV_DICT_KEY;
                     depth++;
                     t.kind = EV_DICT;
                  end
               end else begin
                  e = ERR_UNEXP;
               end
            end
            PH_INT_SIGN, PH_INT_DIG: begin
               if (parse_st == PH_INT_SIGN && b == CH_MINUS) begin
                  int_neg  = 1'b1;
                  parse_st = PH_INT_DIG;
               end else if (is_decimal(b)) begin
                  int_acc  = int_acc * 10 + dig;
                  parse_st = PH_INT_DIG;
               end else if (b == CH_END) begin
                  t.kind = EV_INT;
                  t.ival = int_neg ? (64'd0 - int_acc) : int_acc;
                  finish_value();
               end else begin
                  e = ERR_UNEXP;
               end
            end
            PH_LEN: begin
               if (is_decimal(b)) begin
                  // next digit must keep the length within the counter width
                  if (len_acc > (64'hFFFF_FFFF - dig) / 10) begin
                     e = ERR_LEN_OVF;
                  end else begin
                     len_acc = len_acc * 10 + dig;
                  end
               end else if (b == CH_COLON) begin
                  t.kind    = EV_HDR;
                  t.slen    = len_acc[31:0];
                  t.key     = in_key;
                  body_left = len_acc;
                  if (body_left == 0) begin
                     finish_value();
                  end else begin
                     parse_st = PH_BODY;
                  end
               end else begin
                  e = ERR_UNEXP;
               end
            end
            default: begin
               t.kind    = EV_BYTE;
               t.pbyte   = b;
               t.key     = in_key;
               body_left = body_left - 1;
               if (body_left == 0) finish_value();
            end
         endcase
         // errors leave the count alone; truncation counts the byte
         if (e != ERR_NONE) begin
            sticky   = e;
            parse_st = PH_ERR;
            err_hits[int'(e)]++;
         end else begin
            pos = pos + 1;
            if (last && parse_st != PH_DONE) begin
               sticky   = ERR_TRUNC;
               parse_st = PH_ERR;
               err_hits[int'(ERR_TRUNC)]++;
            end
         end
      end
      t.nest     = depth[4:0];
      t.done     = (parse_st == PH_DONE);
      t.err      = sticky;
      t.consumed = pos;
      ev_hits[int'(t.kind)]++;
      token_q.push_back(t);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   // result ready: random stalls, a long hold on demand
   always @(posedge clock) begin : drive_rsp_ready
      int g;
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else if (steady_flow) begin
         rsp_tready <= 1'b1;
      end else begin
         g = idle_len();
         if (g == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles = g - 1;
         end
      end
   end

   // compare every accepted result with the oldest expected token
   always @(posedge clock) begin : check_tokens
      token_type want;
      if (!reset && req_tvalid && !req_tready) stall_cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (token_q.size() == 0) begin
            report_mismatch("result with nothing expected", 64'd0, {61'd0, rsp_tuser});
         end else begin
            want = token_q.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("event_kind", 64'(want.kind), 64'(rsp_tuser));
            if (rsp_tdata[63:0] !== want.ival)
               report_mismatch("int_value", want.ival, rsp_tdata[63:0]);
            if (rsp_tdata[95:64] !== want.slen)
               report_mismatch("string_length", 64'(want.slen), 64'(rsp_tdata[95:64]));
            if (rsp_tdata[103:96] !== want.pbyte)
               report_mismatch("payload_byte", 64'(want.pbyte), 64'(rsp_tdata[103:96]));
            if (rsp_tdata[104] !== want.key)
               report_mismatch("is_dict_key", 64'(want.key), 64'(rsp_tdata[104]));
            if (rsp_tdata[109:105] !== want.nest)
               report_mismatch("nesting_level", 64'(want.nest), 64'(rsp_tdata[109:105]));
            if (rsp_tdata[110] !== want.done)
               report_mismatch("top_done", 64'(want.done), 64'(rsp_tdata[110]));
            if (rsp_tdata[113:111] !== want.err)
               report_mismatch("error_code", 64'(want.err), 64'(rsp_tdata[113:111]));
            if (rsp_tdata[145:114] !== want.consumed)
               report_mismatch("bytes_consumed", 64'(want.consumed),
                               64'(rsp_tdata[145:114]));
            if (rsp_tdata[151:146] !== 6'd0)
               report_mismatch("padding", 64'd0, 64'(rsp_tdata[151:146]));
         end
      end
   end

   // offer one request and wait for its handshake
   task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
      int gap;
      gap = steady_flow ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tokenize_byte(b, first, last);
      sent_count++;
   endtask

   // stop offering until every expected result has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (token_q.size() != 0) @(posedge clock);
   endtask

   // send the first n encoded bytes as one buffer, optionally pausing at one index
   task automatic send_buffer(input int n, input bit with_last, input int pause_at);
      buffer_count++;
      for (int i = 0; i < n; i++) begin
         if (i == pause_at) wait_results_drained();
         send_byte(enc_q[i], i == 0, with_last && i == n - 1);
      end
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) enc_q.push_back(s[i]);
   endtask

   task automatic send_text(input string s, input bit with_last);
      enc_q.delete();
      push_text(s);
      send_buffer(enc_q.size(), with_last, -1);
   endtask

   // a byte biased toward the encoding's structural characters
   function automatic logic [7:0] token_char();
      case ($urandom_range(0, 9))
         0:       return CH_INT;
         1:       return CH_LIST;
         2:       return CH_DICT;
         3:       return CH_END;
         4:       return CH_COLON;
         5:       return CH_MINUS;
         6, 7:    return 8'(CH_ZERO + $urandom_range(0, 9));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic gen_int();
      int r;
      int n;
      r = $urandom_range(0, 99);
      enc_q.push_back(CH_INT);
      if (r < 5) begin
         push_text("9223372036854775807");
      end else if (r < 10) begin
         push_text("-9223372036854775808");
      end else if (r < 14) begin
         push_text("18446744073709551615");   // wraps to -1
      end else begin
         if ($urandom_range(0, 3) == 0) enc_q.push_back(CH_MINUS);
         n = (r < 25) ? $urandom_range(19, 23) : $urandom_range(0, 4);
         repeat (n) enc_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      enc_q.push_back(CH_END);
   endtask

   task automatic gen_string();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         // largest length: the body runs past the end of the buffer
         push_text("4294967295:");
      end else if (r < 8) begin
         push_text("4294967296:");
      end else begin
         n = (r < 15) ? $urandom_range(6, 12) : $urandom_range(0, 4);
         if (r % 5 == 0) enc_q.push_back(CH_ZERO);
         push_text($sformatf("%0d:", n));
         repeat (n) enc_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic gen_value(input int lvl);
      int r;
      int n;
      r = (lvl >= 3) ? $urandom_range(0, 49) : $urandom_range(0, 99);
      if (r < 25) begin
         gen_int();
      end else if (r < 50) begin
         gen_string();
      end else if (r < 75) begin
         enc_q.push_back(CH_LIST);
         n = $urandom_range(0, 3);
         repeat (n) gen_value(lvl + 1);
         enc_q.push_back(CH_END);
      end else begin
         enc_q.push_back(CH_DICT);
         n = $urandom_range(0, 3);
         repeat (n) begin
            gen_string();
            gen_value(lvl + 1);
         end
         enc_q.push_back(CH_END);
      end
   endtask

   // chain of n nested containers around one integer
   task automatic gen_deep(input int n);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) begin
            enc_q.push_back(CH_DICT);
            push_text("1:");
            enc_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            enc_q.push_back(CH_LIST);
         end
      end
      gen_int();
      repeat (n) enc_q.push_back(CH_END);
   endtask

   // empty integers, and a byte after completion is ignored
   task automatic test_empty_integers();
      send_text("ie", 1'b1);
      send_byte(CH_END, 1'b0, 1'b0);
      send_text("i-e", 1'b1);
   endtask

   // close of an empty list, close in a value slot, at top level, non-string key
   task automatic test_slot_errors();
      send_text("le", 1'b1);
      send_text("d0:e", 1'b1);
      send_text("e", 1'b1);
      send_text("di", 1'b0);
   endtask

   // last marker inside a string body
   task automatic test_truncation();
      send_text("2:a", 1'b1);
   endtask

   task automatic test_length_overflow();
      send_text("4294967296", 1'b1);
   endtask

   // sixteen open lists, then one more container
   task automatic test_depth_limit();
      enc_q.delete();
      repeat (DEPTH_LIMIT) enc_q.push_back(CH_LIST);
      enc_q.push_back(CH_DICT);
      send_buffer(enc_q.size(), 1'b1, -1);
   endtask

   // mostly well-formed buffers with random content, some broken, some noise
   task automatic test_random_buffers(input int budget);
      int stop_at;
      int r;
      int m;
      int n;
      bit with_last;
      int pause_at;
      stop_at = sent_count + budget;
      while (sent_count < stop_at) begin
         enc_q.delete();
         steady_flow = ($urandom_range(0, 9) == 0);
         r = $urandom_range(0, 99);
         if (r < 8) begin
            repeat ($urandom_range(1, 8)) enc_q.push_back(token_char());
         end else if (r < 16) begin
            gen_deep($urandom_range(13, 17));
         end else begin
            gen_value(0);
         end
         n         = enc_q.size();
         with_last = 1'b1;
         pause_at  = -1;
         m         = $urandom_range(0, 99);
         if (m < 10) begin
            n = $urandom_range(1, n);
         end else if (m < 20) begin
            enc_q[$urandom_range(0, n - 1)] = token_char();
         end else if (m < 28) begin
            repeat ($urandom_range(1, 3)) enc_q.push_back(token_char());
            n = enc_q.size();
         end else if (m < 33) begin
            with_last = 1'b0;
         end else if (m < 36 && n > 1) begin
            pause_at = $urandom_range(1, n - 1);
         end
         send_buffer(n, with_last, pause_at);
      end
      steady_flow = 1'b0;
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      rsp_hold_cycles = 250;
      steady_flow     = 1'b1;
      enc_q.delete();
      gen_deep(10);
      send_buffer(enc_q.size(), 1'b1, -1);
      enc_q.delete();
      gen_value(0);
      send_buffer(enc_q.size(), 1'b1, -1);
      steady_flow = 1'b0;
   endtask

   // sender stops mid-buffer and between buffers until all results are back
   task automatic test_drain_pause();
      enc_q.delete();
      while (enc_q.size() < 4) gen_value(0);
      send_buffer(enc_q.size(), 1'b1, enc_q.size() / 2);
      wait_results_drained();
      enc_q.delete();
      gen_value(1);
      send_buffer(enc_q.size(), 1'b1, -1);
   endtask

   initial begin : run_tests
      int waited;
      restart_parse();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_integers();
      test_slot_errors();
      test_truncation();
      test_length_overflow();
      test_depth_limit();
      test_random_buffers(550);
      test_backpressure();
      test_drain_pause();
      test_random_buffers(550);

      // let the last results drain, then check that none are left
      req_tvalid <= 1'b0;
      waited = 0;
      while (token_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (token_q.size() != 0)
         report_mismatch("results never arrived", 64'(token_q.size()), 64'd0);

      $write("covered %0d requests in %0d buffers: ", sent_count, buffer_count);
      $display("int %0d, header %0d, body byte %0d, list %0d, dict %0d, close %0d",
               ev_hits[EV_INT], ev_hits[EV_HDR], ev_hits[EV_BYTE],
               ev_hits[EV_LIST], ev_hits[EV_DICT], ev_hits[EV_CLOSE]);
      $write("completed %0d; unexpected %0d, truncated %0d, ",
             done_count, err_hits[ERR_UNEXP], err_hits[ERR_TRUNC]);
      $display("too deep %0d, length overflow %0d; input stalls %0d",
               err_hits[ERR_DEEP], err_hits[ERR_LEN_OVF], stall_cycles);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
